/* rtl/fpc_pkg.sv */
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the first-person camera block
// Fixed-point formats, reset values, datapath command set and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // angles in Q.16 degrees
  localparam logic signed [25:0] DEG        = 26'sd65536;
  localparam logic signed [25:0] QUARTER    = 26'sd5898240;
  localparam logic signed [25:0] HALF_TURN  = 26'sd11796480;
  localparam logic [33:0]        FULL_TURN  = 34'd23592960;
  localparam logic signed [34:0] PITCH_LIM  = 35'sd5832704;
  // offset that keeps the unwrapped yaw sum positive (256 full turns)
  localparam logic signed [35:0] WRAP_BIAS  = 36'sd6039797760;
  localparam logic [4:0]         WRAP_TOP   = 5'd8;

  // cordic gain start value in Q2.30
  localparam logic signed [32:0] GAIN_Q30   = 33'sd652032874;
  localparam logic signed [19:0] ONE_Q14    = 20'sd16384;

  // reset values
  localparam logic signed [24:0] YAW_RST    = -25'sd5898240;
  localparam logic signed [31:0] POS_Y_RST  = 32'sd327680;
  localparam logic signed [31:0] POS_Z_RST  = 32'sd196608;
  localparam logic signed [15:0] FRONT_Z_RST = -16'sd16384;
  localparam logic signed [15:0] LAST_X_RST = 16'sd640;
  localparam logic signed [15:0] LAST_Y_RST = 16'sd360;
  localparam logic [15:0]        SENS_RST   = 16'd6554;
  localparam logic [15:0]        SPEED_RST  = 16'd1280;

  // configuration register map
  localparam int                 CFG_IDX_W  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 4'd1;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_wr_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_FIRST,
    OP_TURN,
    OP_WRAP,
    OP_COMMIT,
    OP_CINIT_YAW,
    OP_CINIT_PITCH,
    OP_CSTEP,
    OP_SAVE_YAW,
    OP_SAVE_PITCH,
    OP_MULX,
    OP_FX,
    OP_FZ,
    OP_STEP,
    OP_RIGHT,
    OP_MMUL,
    OP_MACC,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] idx;        // cordic step, wrap shift or axis
    logic       dir_right;  // move along right instead of front
    logic       sub;        // subtract the move step
  } dp_cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] keys;       // forward, back, left, right from bit 0
  } dp_status_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
    logic signed [25:0] r;
    unique case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // clamp to +-1.0 in Q1.14
  function automatic logic signed [15:0] sat_q14(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > ONE_Q14) r = 16'sd16384;
    else if (v < -ONE_Q14) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  // Q2.30 to Q1.14 with round half up and clamp
  function automatic logic signed [15:0] q30_to_q14(input logic signed [32:0] v);
    logic signed [33:0] s;
    s = {v[32], v} + 34'sd32768;
    return sat_q14(20'(signed'(s[33:16])));
  endfunction

endpackage

`default_nettype wire

/* rtl/fpc_if.sv */
// ----------------------------------------------------------------------------
// fpc_if: channel interfaces of the first-person camera block
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  logic               key_forward;
  logic               key_back;
  logic               key_left;
  logic               key_right;
  logic [15:0]        delta_time;

  modport source(output valid, opcode, cursor_x, cursor_y, key_forward, key_back,
                 key_left, key_right, delta_time, input ready);
  modport sink(input valid, opcode, cursor_x, cursor_y, key_forward, key_back,
               key_left, key_right, delta_time, output ready);
endinterface

interface fpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [24:0] yaw_angle;
  logic signed [23:0] pitch_angle;

  modport source(output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                 yaw_angle, pitch_angle, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
               yaw_angle, pitch_angle, output ready);
endinterface

interface fpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpc_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/first_person_camera_update.sv */
// ----------------------------------------------------------------------------
// first_person_camera_update: fixed-point first-person camera
// Cursor items turn the view, move items step the position.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per cursor event (opcode 0) or movement tick (opcode 1)
//   out_ch : one beat per input beat with position, front, yaw and pitch
//   cfg    : register writes, always ready, index 0 sensitivity, 1 speed
// Work from input accept to result valid:
//   first cursor event : stores the cursor origin only
//   cursor event       : nine wrap subtract steps and two passes of the
//                        shared cordic unit, one rotation per cycle
//   movement tick      : one multiply and one add per axis and held key
// One item is worked on at a time; in_ch.ready is high while idle, also when
// a finished result waits in the output register.
// If out_ch.ready stays low, the next item runs to completion and then waits
// until the held result has been taken.
// Reset (rst, synchronous) restores the camera pose, the cursor origin,
// the first-event flag and both registers, and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module first_person_camera_update #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  fpc_in_if.sink    in_ch,
  fpc_out_if.source out_ch,
  fpc_cfg_if.sink   cfg
);

  fpc_pkg::dp_cmd_t    cmd;
  fpc_pkg::dp_status_t status;
  fpc_pkg::cfg_wr_t    cfg_wr;

  // config writes are taken every cycle
  assign cfg.ready    = 1'b1;
  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  fpc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_wr     (cfg_wr),
    .opcode     (in_ch.opcode),
    .cursor_x   (in_ch.cursor_x),
    .cursor_y   (in_ch.cursor_y),
    .keys_in    ({in_ch.key_right, in_ch.key_left, in_ch.key_back, in_ch.key_forward}),
    .delta_time (in_ch.delta_time),
    .pos_x      (out_ch.pos_x),
    .pos_y      (out_ch.pos_y),
    .pos_z      (out_ch.pos_z),
    .front_x    (out_ch.front_x),
    .front_y    (out_ch.front_y),
    .front_z    (out_ch.front_z),
    .yaw_angle  (out_ch.yaw_angle),
    .pitch_angle(out_ch.pitch_angle)
  );

endmodule

`default_nettype wire

/* rtl/fpc_ctrl.sv */
// ----------------------------------------------------------------------------
// fpc_ctrl: sequencer of the first-person camera block
// Walks one item through turn, wrap, cordic passes and move steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire fpc_pkg::dp_status_t status,
  output fpc_pkg::dp_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FIRST, S_TURN, S_WRAP, S_COMMIT, S_CINIT, S_CSTEP,
    S_CSAVE, S_MULX, S_FX, S_FZ, S_STEP, S_RIGHT, S_KEY, S_MMUL, S_MACC, S_DONE
  } state_t;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  state_t     state;
  logic       first_event;
  logic       pass;
  logic [4:0] cnt;
  logic [2:0] key_idx;
  logic [1:0] axis;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.op        = fpc_pkg::OP_NOP;
    cmd.dir_right = key_idx[1];
    cmd.sub       = key_idx[0] ^ key_idx[1];
    unique case (state)
      S_IDLE:   cmd.op = in_valid ? fpc_pkg::OP_CAPTURE : fpc_pkg::OP_NOP;
      S_DECODE: cmd.op = fpc_pkg::OP_NOP;
      S_FIRST:  cmd.op = fpc_pkg::OP_FIRST;
      S_TURN:   cmd.op = fpc_pkg::OP_TURN;
      S_WRAP: begin
        cmd.op  = fpc_pkg::OP_WRAP;
        cmd.idx = cnt;
      end
      S_COMMIT: cmd.op = fpc_pkg::OP_COMMIT;
      S_CINIT:  cmd.op = pass ? fpc_pkg::OP_CINIT_PITCH : fpc_pkg::OP_CINIT_YAW;
      S_CSTEP: begin
        cmd.op  = fpc_pkg::OP_CSTEP;
        cmd.idx = cnt;
      end
      S_CSAVE:  cmd.op = pass ? fpc_pkg::OP_SAVE_PITCH : fpc_pkg::OP_SAVE_YAW;
      S_MULX:   cmd.op = fpc_pkg::OP_MULX;
      S_FX:     cmd.op = fpc_pkg::OP_FX;
      S_FZ:     cmd.op = fpc_pkg::OP_FZ;
      S_STEP:   cmd.op = fpc_pkg::OP_STEP;
      S_RIGHT:  cmd.op = fpc_pkg::OP_RIGHT;
      S_KEY:    cmd.op = fpc_pkg::OP_NOP;
      S_MMUL: begin
        cmd.op  = fpc_pkg::OP_MMUL;
        cmd.idx = {3'b000, axis};
      end
      S_MACC: begin
        cmd.op  = fpc_pkg::OP_MACC;
        cmd.idx = {3'b000, axis};
      end
      S_DONE:   cmd.op = out_free ? fpc_pkg::OP_OUT : fpc_pkg::OP_NOP;
      default:  cmd.op = fpc_pkg::OP_NOP;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      first_event <= 1'b1;
      pass        <= 1'b0;
      cnt         <= '0;
      key_idx     <= '0;
      axis        <= '0;
      out_valid   <= 1'b0;
    end else begin
      // valid rises when a result is loaded, falls when it is taken
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          pass <= 1'b0;
          cnt  <= fpc_pkg::WRAP_TOP;
          if (status.opcode) state <= S_STEP;
          else if (first_event) state <= S_FIRST;
          else state <= S_TURN;
        end
        S_FIRST: begin
          first_event <= 1'b0;
          state       <= S_DONE;
        end
        S_TURN: state <= S_WRAP;
        S_WRAP: begin
          if (cnt == 5'd0) state <= S_COMMIT;
          else cnt <= cnt - 5'd1;
        end
        S_COMMIT: state <= S_CINIT;
        S_STEP:   state <= S_CINIT;
        S_CINIT: begin
          cnt   <= '0;
          state <= S_CSTEP;
        end
        S_CSTEP: begin
          if (cnt == LAST_STEP) state <= S_CSAVE;
          else cnt <= cnt + 5'd1;
        end
        S_CSAVE: begin
          if (status.opcode) state <= S_RIGHT;
          else if (pass) state <= S_MULX;
          else begin
            pass  <= 1'b1;
            state <= S_CINIT;
          end
        end
        S_MULX: state <= S_FX;
        S_FX:   state <= S_FZ;
        S_FZ:   state <= S_DONE;
        S_RIGHT: begin
          key_idx <= '0;
          state   <= S_KEY;
        end
        // skip keys that are not held
        S_KEY: begin
          axis <= '0;
          if (key_idx == 3'd4) state <= S_DONE;
          else if (status.keys[key_idx[1:0]]) state <= S_MMUL;
          else key_idx <= key_idx + 3'd1;
        end
        S_MMUL: state <= S_MACC;
        S_MACC: begin
          if (axis == 2'd2) begin
            key_idx <= key_idx + 3'd1;
            state   <= S_KEY;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MMUL;
          end
        end
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/fpc_dp.sv */
// ----------------------------------------------------------------------------
// fpc_dp: datapath of the first-person camera block
// Camera state, angle wrap, shared cordic unit, shared multiplier, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fpc_pkg::dp_cmd_t   cmd,
  output fpc_pkg::dp_status_t     status,
  input  wire fpc_pkg::cfg_wr_t   cfg_wr,
  input  wire logic               opcode,
  input  wire logic signed [15:0] cursor_x,
  input  wire logic signed [15:0] cursor_y,
  input  wire logic [3:0]         keys_in,
  input  wire logic [15:0]        delta_time,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [15:0]      front_x,
  output logic signed [15:0]      front_y,
  output logic signed [15:0]      front_z,
  output logic signed [24:0]      yaw_angle,
  output logic signed [23:0]      pitch_angle
);

  logic [15:0]        sens, speed;
  logic signed [24:0] yaw;
  logic signed [23:0] pitch;
  logic signed [31:0] pos [3];
  logic signed [15:0] front [3];
  logic signed [15:0] last_x, last_y;

  logic               op_q;
  logic signed [15:0] cur_x, cur_y;
  logic [3:0]         keys;
  logic [15:0]        dt;
  logic [33:0]        wrap_v;
  logic signed [34:0] pitch_sum;
  logic signed [32:0] cor_x, cor_y;
  logic signed [25:0] cor_z;
  logic               cor_neg;
  logic signed [32:0] sin_y, cos_y, sin_p, cos_p;
  logic signed [15:0] right_x, right_z;
  logic [31:0]        step;
  logic signed [65:0] prod;

  logic signed [16:0] dx, dy, sens_s;
  logic signed [33:0] yaw_turn, pitch_turn;
  logic signed [35:0] wrap_sum;
  logic [33:0]        wrap_sub;
  logic signed [34:0] pitch_add;
  logic signed [23:0] pitch_lim;
  logic signed [25:0] ang, ang_fold;
  logic               ang_neg;
  logic signed [32:0] xs, ys, sin_f, cos_f;
  logic signed [25:0] at;
  logic signed [32:0] mul_a, mul_b;
  logic signed [15:0] dir_c;
  logic signed [65:0] p46, p22;
  logic signed [15:0] r46;
  logic signed [26:0] dmove;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic [1:0]         ax;

  assign status.opcode = op_q;
  assign status.keys   = keys;
  assign ax            = cmd.idx[1:0];

  // turn sums
  always_comb begin
    dx         = {cur_x[15], cur_x} - {last_x[15], last_x};
    dy         = {last_y[15], last_y} - {cur_y[15], cur_y};
    sens_s     = signed'({1'b0, sens});
    yaw_turn   = 34'(dx) * 34'(sens_s);
    pitch_turn = 34'(dy) * 34'(sens_s);
    wrap_sum   = 36'(yaw) + 36'(yaw_turn) + 36'(fpc_pkg::HALF_TURN) + fpc_pkg::WRAP_BIAS;
    wrap_sub   = fpc_pkg::FULL_TURN << cmd.idx;
    pitch_add  = 35'(pitch) + 35'(pitch_turn);
    if (pitch_sum > fpc_pkg::PITCH_LIM) pitch_lim = 24'(fpc_pkg::PITCH_LIM);
    else if (pitch_sum < -fpc_pkg::PITCH_LIM) pitch_lim = 24'(-fpc_pkg::PITCH_LIM);
    else pitch_lim = pitch_sum[23:0];
  end

  // cordic angle fold and step terms
  always_comb begin
    ang = (cmd.op == fpc_pkg::OP_CINIT_PITCH) ? 26'(pitch) : 26'(yaw);
    if (ang > fpc_pkg::QUARTER) begin
      ang_fold = ang - fpc_pkg::HALF_TURN;
      ang_neg  = 1'b1;
    end else if (ang < -fpc_pkg::QUARTER) begin
      ang_fold = ang + fpc_pkg::HALF_TURN;
      ang_neg  = 1'b1;
    end else begin
      ang_fold = ang;
      ang_neg  = 1'b0;
    end
    xs    = cor_x >>> cmd.idx;
    ys    = cor_y >>> cmd.idx;
    at    = fpc_pkg::atan_deg(cmd.idx);
    sin_f = cor_neg ? -cor_y : cor_y;
    cos_f = cor_neg ? -cor_x : cor_x;
  end

  // shared multiplier operands and rounding
  always_comb begin
    if (cmd.dir_right) begin
      unique case (ax)
        2'd0:    dir_c = right_x;
        2'd2:    dir_c = right_z;
        default: dir_c = '0;
      endcase
    end else begin
      dir_c = (ax == 2'd3) ? 16'sd0 : front[ax];
    end
    unique case (cmd.op)
      fpc_pkg::OP_MULX: begin
        mul_a = cos_y;
        mul_b = cos_p;
      end
      fpc_pkg::OP_FX: begin
        mul_a = sin_y;
        mul_b = cos_p;
      end
      default: begin
        mul_a = signed'({1'b0, step});
        mul_b = 33'(dir_c);
      end
    endcase
    p46     = prod + (66'sd1 <<< 45);
    r46     = fpc_pkg::sat_q14(p46[65:46]);
    p22     = prod + (66'sd1 <<< 21);
    dmove   = p22[48:22];
    pos_sum = cmd.sub ? (34'(pos[ax]) - 34'(dmove)) : (34'(pos[ax]) + 34'(dmove));
    if (pos_sum > 34'sd2147483647) pos_sat = 32'sh7fffffff;
    else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
    else pos_sat = pos_sum[31:0];
  end

  // camera state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sens     <= fpc_pkg::SENS_RST;
      speed    <= fpc_pkg::SPEED_RST;
      yaw      <= fpc_pkg::YAW_RST;
      pitch    <= '0;
      pos[0]   <= '0;
      pos[1]   <= fpc_pkg::POS_Y_RST;
      pos[2]   <= fpc_pkg::POS_Z_RST;
      front[0] <= '0;
      front[1] <= '0;
      front[2] <= fpc_pkg::FRONT_Z_RST;
      last_x   <= fpc_pkg::LAST_X_RST;
      last_y   <= fpc_pkg::LAST_Y_RST;
    end else begin
      if (cfg_wr.en && cfg_wr.index == fpc_pkg::CFG_SENS) sens <= cfg_wr.data;
      if (cfg_wr.en && cfg_wr.index == fpc_pkg::CFG_SPEED) speed <= cfg_wr.data;
      unique case (cmd.op)
        fpc_pkg::OP_FIRST: begin
          last_x <= cur_x;
          last_y <= cur_y;
        end
        fpc_pkg::OP_COMMIT: begin
          yaw    <= 25'(wrap_v - 34'(fpc_pkg::HALF_TURN));
          pitch  <= pitch_lim;
          last_x <= cur_x;
          last_y <= cur_y;
        end
        fpc_pkg::OP_FX:   front[0] <= r46;
        fpc_pkg::OP_FZ: begin
          front[2] <= r46;
          front[1] <= fpc_pkg::q30_to_q14(sin_p);
        end
        fpc_pkg::OP_MACC: pos[ax] <= pos_sat;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      fpc_pkg::OP_CAPTURE: begin
        op_q  <= opcode;
        cur_x <= cursor_x;
        cur_y <= cursor_y;
        keys  <= keys_in;
        dt    <= delta_time;
      end
      fpc_pkg::OP_TURN: begin
        wrap_v    <= wrap_sum[33:0];
        pitch_sum <= pitch_add;
      end
      // one compare and subtract of a shifted full turn
      fpc_pkg::OP_WRAP: if (wrap_v >= wrap_sub) wrap_v <= wrap_v - wrap_sub;
      fpc_pkg::OP_CINIT_YAW, fpc_pkg::OP_CINIT_PITCH: begin
        cor_x   <= fpc_pkg::GAIN_Q30;
        cor_y   <= '0;
        cor_z   <= ang_fold;
        cor_neg <= ang_neg;
      end
      fpc_pkg::OP_CSTEP: begin
        if (!cor_z[25]) begin
          cor_x <= cor_x - ys;
          cor_y <= cor_y + xs;
          cor_z <= cor_z - at;
        end else begin
          cor_x <= cor_x + ys;
          cor_y <= cor_y - xs;
          cor_z <= cor_z + at;
        end
      end
      fpc_pkg::OP_SAVE_YAW: begin
        sin_y <= sin_f;
        cos_y <= cos_f;
      end
      fpc_pkg::OP_SAVE_PITCH: begin
        sin_p <= sin_f;
        cos_p <= cos_f;
      end
      fpc_pkg::OP_MULX, fpc_pkg::OP_FX, fpc_pkg::OP_MMUL: prod <= mul_a * mul_b;
      fpc_pkg::OP_STEP: step <= speed * dt;
      fpc_pkg::OP_RIGHT: begin
        right_x <= -fpc_pkg::q30_to_q14(sin_y);
        right_z <= fpc_pkg::q30_to_q14(cos_y);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == fpc_pkg::OP_OUT) begin
      pos_x       <= pos[0];
      pos_y       <= pos[1];
      pos_z       <= pos[2];
      front_x     <= front[0];
      front_y     <= front[1];
      front_z     <= front[2];
      yaw_angle   <= yaw;
      pitch_angle <= pitch;
    end
  end

endmodule

`default_nettype wire

/* rtl/fpc_checker.sv */
// ----------------------------------------------------------------------------
// fpc_checker: port-level checks of the first-person camera block
// Result handshake, one-at-a-time intake and range of result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] front_x,
  input wire logic signed [15:0] front_z,
  input wire logic signed [24:0] yaw_angle,
  input wire logic signed [23:0] pitch_angle
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // intake closes after a beat until the item is done
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // nothing to show right after reset
  a_rst_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // view direction stays within unit range
  a_front_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> front_x <= 16'sd16384 && front_x >= -16'sd16384 &&
                  front_z <= 16'sd16384 && front_z >= -16'sd16384)
    else $error("front component out of range");

  // wrapped yaw and clamped pitch
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_angle >= -25'sd11796480 && yaw_angle < 25'sd11796480 &&
                  pitch_angle <= 24'sd5832704 && pitch_angle >= -24'sd5832704)
    else $error("angle out of range");

endmodule

bind first_person_camera_update fpc_checker u_fpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .front_x    (out_ch.front_x),
  .front_z    (out_ch.front_z),
  .yaw_angle  (out_ch.yaw_angle),
  .pitch_angle(out_ch.pitch_angle)
);

`default_nettype wire

/* dv/fpc_camera_checker.sv */
// ----------------------------------------------------------------------------
// fpc_camera_checker: pose predictor and result checker for the camera block
// Watches the input, result and register write channels, predicts the camera
// pose after every accepted input beat and compares each result field.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_camera_checker (
  input  wire logic clk,
  input  wire logic rst,
  fpc_in_if.sink    in_ch,
  fpc_out_if.sink   out_ch,
  fpc_cfg_if.sink   cfg,
  output int        fail_count,
  output int        pending,
  output int        result_count
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic signed [24:0] yaw;
    logic signed [23:0] pitch;
  } pose_t;

  localparam longint ONE_DEG = 65536;
  localparam int     STEPS   = 16;

  pose_t  pose_queue[$];
  longint sens, speed, yaw_q16, pitch_q16, last_x, last_y;
  longint pos[3];
  longint front[3];
  bit     awaiting_first;

  // floor division by a power of two
  function automatic longint floor_shr(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-(v + 1)) >>> n) - 1;
  endfunction

  function automatic longint round_shr(longint v, int n);
    return floor_shr(v + (longint'(1) <<< (n - 1)), n);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_q16(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // rotation-mode sin/cos in Q2.30, angle folded into +-90 degrees
  task automatic rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, xs, ys;
    bit     flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > 90 * ONE_DEG) begin
      ang -= 180 * ONE_DEG; flip = 1;
    end else if (ang < -90 * ONE_DEG) begin
      ang += 180 * ONE_DEG; flip = 1;
    end
    z = ang;
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_q16(i);
      end else begin
        x += ys; y -= xs; z += arctan_q16(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint to_q14(longint v);
    return clip(round_shr(v, 16), -16384, 16384);
  endfunction

  task automatic step_along(input longint dir[3], input longint travel, input bit add);
    longint d;
    for (int k = 0; k < 3; k++) begin
      d = round_shr(travel * dir[k], 22);
      pos[k] = clip(add ? pos[k] + d : pos[k] - d, -64'sd2147483648, 64'sd2147483647);
    end
  endtask

  task automatic restore_pose();
    sens = 6554; speed = 1280;
    yaw_q16 = -90 * ONE_DEG; pitch_q16 = 0;
    pos = '{0, 5 * ONE_DEG, 3 * ONE_DEG};
    front = '{0, 0, -16384};
    last_x = 640; last_y = 360;
    awaiting_first = 1;
  endtask

  // advance the pose for one accepted input beat
  task automatic predict_pose();
    longint cx, cy, y, sy, cyw, sp, cp, travel;
    longint side[3];
    pose_t  p;
    if (in_ch.opcode == 1'b0) begin
      cx = longint'(in_ch.cursor_x);
      cy = longint'(in_ch.cursor_y);
      if (awaiting_first) awaiting_first = 0;
      else begin
        y = (yaw_q16 + (cx - last_x) * sens + 180 * ONE_DEG) % (360 * ONE_DEG);
        if (y < 0) y += 360 * ONE_DEG;
        yaw_q16 = y - 180 * ONE_DEG;
        pitch_q16 = clip(pitch_q16 + (last_y - cy) * sens, -89 * ONE_DEG, 89 * ONE_DEG);
        rotate(yaw_q16, sy, cyw);
        rotate(pitch_q16, sp, cp);
        front[0] = clip(round_shr(cyw * cp, 46), -16384, 16384);
        front[1] = to_q14(sp);
        front[2] = clip(round_shr(sy * cp, 46), -16384, 16384);
      end
      last_x = cx; last_y = cy;
    end else begin
      travel = speed * longint'(in_ch.delta_time);
      rotate(yaw_q16, sy, cyw);
      side = '{-to_q14(sy), 0, to_q14(cyw)};
      if (in_ch.key_forward) step_along(front, travel, 1);
      if (in_ch.key_back)    step_along(front, travel, 0);
      if (in_ch.key_left)    step_along(side, travel, 0);
      if (in_ch.key_right)   step_along(side, travel, 1);
    end
    p.px = 32'(pos[0]); p.py = 32'(pos[1]); p.pz = 32'(pos[2]);
    p.fx = 16'(front[0]); p.fy = 16'(front[1]); p.fz = 16'(front[2]);
    p.yaw = 25'(yaw_q16); p.pitch = 24'(pitch_q16);
    pose_queue.push_back(p);
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // sample the channels at each edge
  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      restore_pose();
      pose_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == fpc_pkg::CFG_SENS) sens = cfg.data;
        else if (cfg.index == fpc_pkg::CFG_SPEED) speed = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) predict_pose();
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (pose_queue.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat, nothing expected", $time);
        end else begin
          e = pose_queue.pop_front();
          compare_field("pos_x", e.px, out_ch.pos_x);
          compare_field("pos_y", e.py, out_ch.pos_y);
          compare_field("pos_z", e.pz, out_ch.pos_z);
          compare_field("front_x", e.fx, out_ch.front_x);
          compare_field("front_y", e.fy, out_ch.front_y);
          compare_field("front_z", e.fz, out_ch.front_z);
          compare_field("yaw_angle", e.yaw, out_ch.yaw_angle);
          compare_field("pitch_angle", e.pitch, out_ch.pitch_angle);
        end
      end
    end
    pending = pose_queue.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    restore_pose();
  end

endmodule

`default_nettype wire

/* dv/first_person_camera_update_tb.sv */
// ----------------------------------------------------------------------------
// first_person_camera_update_tb: stimulus and verdict for the camera block
// Directed corner beats, then random cursor/move beats across several
// sensitivity and speed settings and idle/stall phases; a checker compares.
// ----------------------------------------------------------------------------
`default_nettype none

module first_person_camera_update_tb;

  logic clk;
  logic rst;
  int   fail_count, pending, result_count;
  int   send_idle_pct, recv_stall_pct;
  int   hold_off;
  int   beats_sent;

  fpc_in_if  in_ch();
  fpc_out_if out_ch();
  fpc_cfg_if cfg();

  first_person_camera_update u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  fpc_camera_checker u_check (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result-side ready with random stalls and a long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one input beat, waiting out random sender gaps; valid stays up for the next
  task automatic send_beat(input logic op, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic [3:0] keys,
                           input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.cursor_x <= x;
    in_ch.cursor_y <= y;
    {in_ch.key_right, in_ch.key_left, in_ch.key_back, in_ch.key_forward} <= keys;
    in_ch.delta_time <= dt;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  // mostly small cursor moves, some wild jumps; moves with random keys
  task automatic random_beats(input int n);
    logic signed [15:0] cx, cy;
    cx = 0;
    cy = 0;
    repeat (n) begin
      if ($urandom_range(1)) begin
        if ($urandom_range(9) == 0) begin
          cx = 16'($urandom); cy = 16'($urandom);
        end else begin
          cx += $signed(16'($urandom_range(400))) - 16'sd200;
          cy += $signed(16'($urandom_range(400))) - 16'sd200;
        end
        send_beat(0, cx, cy, 4'($urandom), 16'($urandom));
      end else begin
        send_beat(1, 16'($urandom), 16'($urandom), 4'($urandom),
                  ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3000)));
      end
    end
  endtask

  initial begin
    int sens_set[5] = '{0, 65535, 6554, 1, 30000};
    int speed_set[5] = '{65535, 0, 1280, 1, 20000};
    rst = 1;
    hold_off = 0;
    beats_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 0; in_ch.opcode = 0; in_ch.cursor_x = 0; in_ch.cursor_y = 0;
    in_ch.key_forward = 0; in_ch.key_back = 0; in_ch.key_left = 0;
    in_ch.key_right = 0; in_ch.delta_time = 0;
    cfg.valid = 0; cfg.index = fpc_pkg::CFG_SENS; cfg.data = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first cursor event, corners of cursor, keys and time
    send_beat(1, 0, 0, 4'b0001, 16'hFFFF);
    send_beat(0, 16'sh7FFF, -16'sh8000, 4'hF, 16'hFFFF);
    send_beat(0, -16'sh8000, 16'sh7FFF, 4'h0, 0);
    send_beat(0, 16'sh7FFF, -16'sh8000, 4'h0, 0);
    send_beat(0, 16'sh7FFF, -16'sh8000, 4'h0, 0);
    send_beat(1, 0, 0, 4'hF, 16'hFFFF);
    for (int k = 0; k < 4; k++) send_beat(1, 0, 0, 4'(1 << k), 16'hFFFF);
    send_beat(1, 0, 0, 4'b0101, 0);
    drain();
    write_reg(fpc_pkg::CFG_SENS, 16'hFFFF);
    write_reg(fpc_pkg::CFG_SPEED, 16'hFFFF);
    send_beat(0, 16'sd100, 16'sd100, 4'h0, 0);
    send_beat(0, -16'sd100, -16'sd300, 4'h0, 0);
    send_beat(0, 16'sd3, 16'sd2000, 4'h0, 0);
    // large moves with forward and right, then back and left held
    repeat (6) send_beat(1, 0, 0, 4'b1001, 16'hFFFF);
    repeat (6) send_beat(1, 0, 0, 4'b0110, 16'hFFFF);

    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    random_beats(10);
    // sender pause until everything is back
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(fpc_pkg::CFG_SENS, 16'(sens_set[ph]));
      write_reg(fpc_pkg::CFG_SPEED, 16'(speed_set[ph]));
      send_idle_pct = 0;  recv_stall_pct = 0;  random_beats(90);
      send_idle_pct = 68; recv_stall_pct = 0;  random_beats(80);
      send_idle_pct = 0;  recv_stall_pct = 68; random_beats(80);
      send_idle_pct = 32; recv_stall_pct = 32; random_beats(90);
      send_idle_pct = 0;  recv_stall_pct = 0;
      drain();
    end

    $display("covered %0d input beats and %0d results over five register settings",
             beats_sent, result_count);
    $display("with idle, stall, hold-off and drain phases");
    if (fail_count == 0) begin
      $display("first_person_camera_update_tb: clean");
    end else begin
      $display("first_person_camera_update_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("first_person_camera_update_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
